// File: design/rc5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_pkg: shared types and constants for the RC5-32 encryption block
// Round count, key table geometry, command codes, controller state and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package rc5_pkg;

	localparam int ROUND_COUNT = 12;
	localparam int KEY_WORDS   = 2 * ROUND_COUNT + 2;
	localparam int WORD_W      = 32;
	localparam int BLOCK_W     = 2 * WORD_W;
	localparam int ROT_W       = 5;
	localparam int KIDX_W      = 5;
	// round counter holds 0..ROUND_COUNT; it doubles as the key pair index
	localparam int RND_W       = $clog2(ROUND_COUNT + 1);
	localparam int KEY_AW      = RND_W + 1;

	typedef enum logic {
		CMD_KEY_WRITE = 1'b0,
		CMD_ENCRYPT   = 1'b1
	} rc5_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND
	} rc5_state_t;

	typedef struct packed {
		logic             key_write; // store key_word at key_index
		logic             capture;   // latch the plaintext block
		logic             load;      // A/B = block halves plus S[0], S[1]
		logic             round_en;  // advance A/B by one round
		logic             out_load;  // latch the ciphertext into the output register
		logic [RND_W-1:0] pair;      // key pair read for the next cycle
	} rc5_cmd_t;

endpackage

// File: design/rc5_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_ifs: valid/ready channels of the RC5-32 encryption block
// Request channel carries key writes and plaintext blocks; response channel
// carries ciphertext blocks.
// ----------------------------------------------------------------------------
interface rc5_req_if;
	import rc5_pkg::*;

	logic              valid;
	logic              ready;
	logic              command;
	logic [KIDX_W-1:0] key_index;
	logic [WORD_W-1:0] key_word;
	logic [BLOCK_W-1:0] data_block;

	modport source (output valid, command, key_index, key_word, data_block, input ready);
	modport sink   (input valid, command, key_index, key_word, data_block, output ready);
endinterface

interface rc5_rsp_if;
	import rc5_pkg::*;

	logic               valid;
	logic               ready;
	logic [BLOCK_W-1:0] cipher_block;

	modport source (output valid, cipher_block, input ready);
	modport sink   (input valid, cipher_block, output ready);
endinterface

// File: design/rc5_block_encrypt_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_block_encrypt_top: RC5-32/12 block encryption with a preloaded key table
// Key write transactions fill the expanded key table; encrypt transactions
// return one ciphertext block each.
// ----------------------------------------------------------------------------
//
// channel  dir  transaction payload
// -------  ---  -------------------------------------------------
// req      in   command, key_index, key_word, data_block
// rsp      out  cipher_block (A in bits 63..32, B in bits 31..0)
//
// A key write leaves the sequencer idle. An encrypt holds the request side
// until its last round: the accept cycle reads S[0]/S[1], the next cycle adds
// them to the block halves, then one round per cycle, bar a stall before the
// last, through the single round unit fed by the two registered key read ports.
// Reset clears the sequencer and the response valid flag; the key table holds
// garbage until written.
// A result waits in the output register while the next transaction is taken;
// the last round of the following encrypt holds until that register is free.
//
module rc5_block_encrypt_top import rc5_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	rc5_req_if.sink    req,
	rc5_rsp_if.source  rsp
);

	rc5_cmd_t cmd;

	// sequencer: decode, round count, response valid
	rc5_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_command (req.command),
		.req_ready   (req.ready),
		.rsp_valid   (rsp.valid),
		.rsp_ready   (rsp.ready),
		.cmd         (cmd)
	);

	// key table, A/B round registers, ciphertext register
	rc5_datapath u_datapath (
		.clk          (clk),
		.cmd          (cmd),
		.key_index    (req.key_index),
		.key_word     (req.key_word),
		.data_block   (req.data_block),
		.cipher_block (rsp.cipher_block)
	);

endmodule

// File: design/rc5_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_ctrl: sequencer of the RC5-32 encryption block
// Decodes request transactions, steps the round counter and owns the
// response valid flag.
// ----------------------------------------------------------------------------
module rc5_ctrl import rc5_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic     req_command,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output rc5_cmd_t cmd
);

	rc5_state_t       state_q, state_d;
	logic [RND_W-1:0] round_q, round_d;
	logic             out_valid_q;
	logic             last;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = out_valid_q;
	assign last      = (round_q == RND_W'(ROUND_COUNT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		round_d = round_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req_command == CMD_ENCRYPT) begin
						cmd.capture = 1'b1;
						state_d     = ST_LOAD;
					end else begin
						cmd.key_write = 1'b1;
					end
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				cmd.pair = RND_W'(1);
				round_d  = RND_W'(1);
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				if (!last) begin
					cmd.round_en = 1'b1;
					cmd.pair     = RND_W'(round_q + 1'b1);
					round_d      = RND_W'(round_q + 1'b1);
				end else begin
					// keep the last key pair on the read ports while the output stalls
					cmd.pair = round_q;
					if (!out_valid_q || rsp_ready) begin
						// final round only once the output register is free
						cmd.round_en = 1'b1;
						cmd.out_load = 1'b1;
						round_d      = '0;
						state_d      = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_capture_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.load)
		else $error("plaintext capture not followed by load");

	a_out_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (state_q == ST_ROUND) && last)
		else $error("ciphertext latched before the last round");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("pending ciphertext overwritten");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (round_q >= RND_W'(1)) && (round_q <= RND_W'(ROUND_COUNT)))
		else $error("round counter out of range");

endmodule

// File: design/rc5_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc5_datapath: key table and round unit of the RC5-32 encryption block
// Key memory with one write and two registered reads, A/B registers with one
// full round per cycle when a round is enabled, and the ciphertext output register.
// ----------------------------------------------------------------------------
module rc5_datapath import rc5_pkg::*; (
	input  logic               clk,
	input  rc5_cmd_t           cmd,
	input  logic [KIDX_W-1:0]  key_index,
	input  logic [WORD_W-1:0]  key_word,
	input  logic [BLOCK_W-1:0] data_block,
	output logic [BLOCK_W-1:0] cipher_block
);

	logic [WORD_W-1:0]  key_mem [KEY_WORDS];
	logic [WORD_W-1:0]  key_even_q, key_odd_q;
	logic [BLOCK_W-1:0] blk_q;
	logic [WORD_W-1:0]  a_q, b_q;
	logic [BLOCK_W-1:0] cipher_q;
	logic [WORD_W-1:0]  a_n, b_n;
	logic               idx_ok;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
	                                           input logic [ROT_W-1:0] n);
		logic [BLOCK_W-1:0] d;
		d = {v, v} << n;
		return d[BLOCK_W-1:WORD_W];
	endfunction

	// writes beyond the table are dropped
	assign idx_ok = (int'(key_index) < KEY_WORDS);

	always_ff @(posedge clk) begin
		if (cmd.key_write && idx_ok) begin
			key_mem[KEY_AW'(key_index)] <= key_word;
		end
	end

	always_ff @(posedge clk) begin
		key_even_q <= key_mem[{cmd.pair, 1'b0}];
		key_odd_q  <= key_mem[{cmd.pair, 1'b1}];
	end

	assign a_n = rotl(a_q ^ b_q, b_q[ROT_W-1:0]) + key_even_q;
	assign b_n = rotl(b_q ^ a_n, a_n[ROT_W-1:0]) + key_odd_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			blk_q <= data_block;
		end
		if (cmd.load) begin
			a_q <= blk_q[BLOCK_W-1:WORD_W] + key_even_q;
			b_q <= blk_q[WORD_W-1:0] + key_odd_q;
		end else if (cmd.round_en) begin
			a_q <= a_n;
			b_q <= b_n;
		end
		if (cmd.out_load) begin
			cipher_q <= {a_n, b_n};
		end
	end

	assign cipher_block = cipher_q;

endmodule
